>>> rtl/lzssd_pkg.sv
// ----------------------------------------------------------------------------
// lzssd_pkg
// shared types and constants for the lzss stream decoder
// ----------------------------------------------------------------------------
package lzssd_pkg;

  // literal field width and the fill byte of the preset window
  localparam int unsigned LIT_BITS   = 8;
  localparam logic [7:0]  SPACE_CHAR = 8'h20;

  // width of the token field bit counter (covers position fields up to 15 bits)
  localparam int unsigned BL_W = 4;

  // token parser phase
  typedef enum logic [1:0] {
    PH_FLAG = 2'd0,
    PH_LIT  = 2'd1,
    PH_POS  = 2'd2,
    PH_LEN  = 2'd3
  } phase_t;

  // sequencer states
  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_BIT  = 5'b00010,
    S_LIT  = 5'b00100,
    S_RD   = 5'b01000,
    S_WR   = 5'b10000
  } state_t;

  // one decoded byte on its way to the output register and the window
  typedef struct packed {
    logic       vld;
    logic       last;
    logic [7:0] data;
  } emit_t;

endpackage

>>> rtl/lzssd_window.sv
// ----------------------------------------------------------------------------
// lzssd_window
// history ring: single memory, write pointer and fill count for preset values
// ----------------------------------------------------------------------------
module lzssd_window
  import lzssd_pkg::*;
#(
  parameter int unsigned POS_BITS = 10,
  parameter int unsigned LEN_BITS = 4
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                rd_en,
  input  logic [POS_BITS-1:0] rd_addr,
  output logic [7:0]          rd_byte,
  input  emit_t               wr
);

  localparam int unsigned WIN_N = 1 << POS_BITS;
  localparam int unsigned LOOK  = (1 << LEN_BITS) + 1;
  localparam logic [POS_BITS-1:0] BASE = POS_BITS'(WIN_N - LOOK);
  localparam logic [POS_BITS:0]   FULL = (POS_BITS+1)'(WIN_N);

  logic [7:0]          mem [WIN_N];
  logic [POS_BITS-1:0] wpos_r, wpos_nxt;
  logic [POS_BITS:0]   fill_r, fill_nxt;
  logic [7:0]          rd_data_r;
  logic                rd_written_r;
  logic                rd_low_r;
  logic [POS_BITS-1:0] rd_ofs;

  // entries are written in ring order from BASE, so the fill count tells
  // which ones still hold their preset value
  assign rd_ofs = rd_addr - BASE;

  always_comb begin
    wpos_nxt = wpos_r;
    fill_nxt = fill_r;
    if (wr.vld) begin
      wpos_nxt = wpos_r + POS_BITS'(1);
      if (fill_r != FULL) begin
        fill_nxt = fill_r + (POS_BITS+1)'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wpos_r <= BASE;
      fill_r <= '0;
    end else begin
      wpos_r <= wpos_nxt;
      fill_r <= fill_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (wr.vld) begin
      mem[wpos_r] <= wr.data;
    end
    if (rd_en) begin
      rd_data_r    <= mem[rd_addr];
      rd_written_r <= ({1'b0, rd_ofs} < fill_r);
      rd_low_r     <= (rd_addr < BASE);
    end
  end

  always_comb begin
    if (rd_written_r) begin
      rd_byte = rd_data_r;
    end else if (rd_low_r) begin
      rd_byte = SPACE_CHAR;
    end else begin
      rd_byte = '0;
    end
  end

endmodule

>>> rtl/lzssd_seq.sv
// ----------------------------------------------------------------------------
// lzssd_seq
// bit-serial token parser and copy sequencer
// ----------------------------------------------------------------------------
module lzssd_seq
  import lzssd_pkg::*;
#(
  parameter int unsigned POS_BITS = 10,
  parameter int unsigned LEN_BITS = 4
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  input  logic [7:0]          in_byte,
  output logic                in_stall,
  input  logic                out_free,
  output emit_t               emit,
  output logic                rd_en,
  output logic [POS_BITS-1:0] rd_addr,
  input  logic [7:0]          rd_byte
);

  localparam int unsigned CL_W = LEN_BITS + 1;

  state_t              state_r, state_nxt;
  phase_t              phase_r, phase_nxt;
  logic [7:0]          sh_r, sh_nxt;
  logic [3:0]          bits_rem_r, bits_rem_nxt;
  logic [BL_W-1:0]     bl_r, bl_nxt;
  logic [POS_BITS-1:0] fa_r, fa_nxt;
  logic [POS_BITS-1:0] match_r, match_nxt;
  logic [POS_BITS-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CL_W-1:0]     cl_r, cl_nxt;

  logic                bit_in;
  logic [POS_BITS-1:0] fa_acc;
  logic [BL_W-1:0]     bl_dec;
  state_t              after_tok;

  assign in_stall = !(state_r == S_IDLE);
  assign rd_addr  = rd_ptr_r;
  assign bit_in   = sh_r[7];
  assign fa_acc   = {fa_r[POS_BITS-2:0], bit_in};
  assign bl_dec   = (bl_r != '0) ? bl_r - BL_W'(1) : bl_r;

  always_comb begin
    state_nxt    = state_r;
    phase_nxt    = phase_r;
    sh_nxt       = sh_r;
    bits_rem_nxt = bits_rem_r;
    bl_nxt       = bl_r;
    fa_nxt       = fa_r;
    match_nxt    = match_r;
    rd_ptr_nxt   = rd_ptr_r;
    cl_nxt       = cl_r;
    rd_en        = 1'b0;
    emit         = '0;
    emit.data    = (state_r == S_WR) ? rd_byte : fa_r[7:0];
    // where to go once a token's output is done
    after_tok    = (bits_rem_r != '0) ? S_BIT : S_IDLE;

    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          sh_nxt       = in_byte;
          bits_rem_nxt = 4'(LIT_BITS);
          state_nxt    = S_BIT;
        end
      end
      S_BIT: begin
        sh_nxt       = {sh_r[6:0], 1'b0};
        bits_rem_nxt = bits_rem_r - 4'd1;
        state_nxt    = (bits_rem_r != 4'd1) ? S_BIT : S_IDLE;
        if (phase_r == PH_FLAG) begin
          fa_nxt = '0;
          if (bit_in) begin
            phase_nxt = PH_LIT;
            bl_nxt    = BL_W'(LIT_BITS);
          end else begin
            phase_nxt = PH_POS;
            bl_nxt    = BL_W'(POS_BITS);
          end
        end else begin
          fa_nxt = fa_acc;
          bl_nxt = bl_dec;
          if (bl_dec == '0) begin
            case (phase_r)
              PH_LIT: begin
                phase_nxt = PH_FLAG;
                state_nxt = S_LIT;
              end
              PH_POS: begin
                match_nxt = fa_acc;
                fa_nxt    = '0;
                phase_nxt = PH_LEN;
                bl_nxt    = BL_W'(LEN_BITS);
              end
              PH_LEN: begin
                cl_nxt     = CL_W'(fa_acc[LEN_BITS-1:0]) + CL_W'(2);
                rd_ptr_nxt = match_r;
                fa_nxt     = '0;
                phase_nxt  = PH_FLAG;
                state_nxt  = S_RD;
              end
              default: begin
                phase_nxt = PH_FLAG;
              end
            endcase
          end
        end
      end
      S_LIT: begin
        if (out_free) begin
          emit.vld  = 1'b1;
          emit.last = 1'b1;
          state_nxt = after_tok;
        end
      end
      S_RD: begin
        rd_en     = 1'b1;
        state_nxt = S_WR;
      end
      S_WR: begin
        if (out_free) begin
          emit.vld   = 1'b1;
          emit.last  = (cl_r == CL_W'(1));
          rd_ptr_nxt = rd_ptr_r + POS_BITS'(1);
          cl_nxt     = cl_r - CL_W'(1);
          state_nxt  = (cl_r == CL_W'(1)) ? after_tok : S_RD;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_IDLE;
      phase_r    <= PH_FLAG;
      bits_rem_r <= '0;
      bl_r       <= '0;
      fa_r       <= '0;
      match_r    <= '0;
      cl_r       <= '0;
    end else begin
      state_r    <= state_nxt;
      phase_r    <= phase_nxt;
      bits_rem_r <= bits_rem_nxt;
      bl_r       <= bl_nxt;
      fa_r       <= fa_nxt;
      match_r    <= match_nxt;
      cl_r       <= cl_nxt;
    end
  end

  always_ff @(posedge clk) begin
    sh_r     <= sh_nxt;
    rd_ptr_r <= rd_ptr_nxt;
  end

endmodule

>>> rtl/lzss_stream_decoder.sv
// ----------------------------------------------------------------------------
// lzss_stream_decoder
// lzss decompressor taking one compressed byte per request
// ----------------------------------------------------------------------------
// Each accepted byte is parsed one bit per cycle, most significant bit first,
// with parsing held while a finished token is output. A finished literal adds
// its emit; a finished match adds, for each of its length+2 copied bytes, a
// read of the history memory, then the emit and write-back. Each emit waits
// for room in the output register. One request is taken at a time: in_stall
// holds until a request's bits and token output are done. The history ring
// needs no clearing pass after reset: a fill count tracks which entries have
// been written since reset, and any other entry reads back as its preset value
// (space below 2**POS_BITS - 2**LEN_BITS - 1, zero above). out_last_of_run
// marks the final result produced by a request; a request that completes no
// token produces no result.
module lzss_stream_decoder
  import lzssd_pkg::*;
#(
  parameter int unsigned POS_BITS = 10,
  parameter int unsigned LEN_BITS = 4
) (
  input  logic       clk,
  input  logic       rst_n,
  // compressed byte requests
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_byte,
  // decoded byte requests
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] out_byte,
  output logic       out_last_of_run
);

  emit_t               emit;
  logic                out_free;
  logic                rd_en;
  logic [POS_BITS-1:0] rd_addr;
  logic [7:0]          rd_byte;

  logic                out_valid_r, out_valid_nxt;
  logic [7:0]          out_byte_r;
  logic                out_last_r;

  // output register can take a new byte when empty or being drained
  assign out_free = !out_valid_r || !out_stall;

  lzssd_seq #(
    .POS_BITS (POS_BITS),
    .LEN_BITS (LEN_BITS)
  ) u_seq (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_byte  (in_byte),
    .in_stall (in_stall),
    .out_free (out_free),
    .emit     (emit),
    .rd_en    (rd_en),
    .rd_addr  (rd_addr),
    .rd_byte  (rd_byte)
  );

  // every emitted byte is also written back into the history ring
  lzssd_window #(
    .POS_BITS (POS_BITS),
    .LEN_BITS (LEN_BITS)
  ) u_window (
    .clk     (clk),
    .rst_n   (rst_n),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_byte (rd_byte),
    .wr      (emit)
  );

  // output holding register
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (emit.vld) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (emit.vld) begin
      out_byte_r <= emit.data;
      out_last_r <= emit.last;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_byte        = out_byte_r;
  assign out_last_of_run = out_last_r;

`ifndef ASSERT_OFF
  // a byte is only produced when the output register has room
  a_emit_room: assert property (@(posedge clk) disable iff (!rst_n)
    emit.vld |-> out_free)
    else $error("decoded byte produced while output register full");

  // once a request is taken the decoder is busy on the next cycle
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> in_stall)
    else $error("decoder ready straight after taking a request");

  // nothing is produced while waiting for a new request
  a_idle_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    !in_stall |-> !emit.vld)
    else $error("decoded byte produced while idle");
`endif

endmodule
